// File: design/sepa_pkg.sv
// Shared types and constants for the STUN endpoint attribute parser.
// Used by the parser core, the input and output stages and the top level.
// No dependencies.
package sepa_pkg;

   localparam int unsigned POS_W = 17;

   localparam logic [POS_W-1:0] POS_MAX      = '1;
   localparam logic [POS_W-1:0] HEADER_BYTES = 17'd20;
   localparam logic [POS_W-1:0] HEADER_LAST  = 17'd19;
   localparam logic [POS_W-1:0] ATTR_HEAD    = 17'd4;

   localparam logic [15:0] BIND_SUCCESS_TYPE = 16'h0101;
   localparam logic [7:0]  FAMILY_V4         = 8'h01;
   localparam logic [7:0]  FAMILY_V6         = 8'h02;
   localparam logic [15:0] V4_LENGTH         = 16'd8;
   localparam logic [15:0] V6_LENGTH         = 16'd20;
   localparam logic [15:0] WANTED_RESET      = 16'h0001;

   typedef enum logic [2:0] {
      ST_FOUND      = 3'd0,
      ST_MISSING    = 3'd1,
      ST_ABSENT     = 3'd2,
      ST_OVERRUN    = 3'd3,
      ST_BAD_LENGTH = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      AF_NONE = 2'd0,
      AF_IPV4 = 2'd1,
      AF_IPV6 = 2'd2
   } family_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_last;
   } item_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] message_type;
      family_type  address_family;
      logic [15:0] port_number;
      logic [63:0] address_upper;
      logic [63:0] address_lower;
   } result_type;

endpackage

// File: design/sepa_if.sv
// Handshake channels of the STUN endpoint attribute parser: byte input,
// result output and the configuration write port.
// No dependencies.
interface sepa_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_last;

   modport source (output valid, output data_byte, output is_last, input ready);
   modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

interface sepa_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] message_type;
   logic [1:0]  address_family;
   logic [15:0] port_number;
   logic [63:0] address_upper;
   logic [63:0] address_lower;

   modport source (output valid, output status, output message_type,
                   output address_family, output port_number,
                   output address_upper, output address_lower, input ready);
   modport sink   (input valid, input status, input message_type,
                   input address_family, input port_number,
                   input address_upper, input address_lower, output ready);
endinterface

interface sepa_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] wanted_attribute;

   modport source (output valid, output wanted_attribute, input ready);
   modport sink   (input valid, input wanted_attribute, output ready);
endinterface

// File: design/sepa_in_stage.sv
// Input register of the STUN endpoint attribute parser.
// Depends on sepa_pkg and sepa_req_if.
module sepa_in_stage import sepa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   sepa_req_if.sink req,
   input  logic     take,
   output logic     item_vld,
   output item_type item
);

   logic     vld_ff, vld_in;
   item_type item_ff, item_in;
   logic     req_fire;

   // The register refills in the same cycle that the core drains it.
   assign req.ready = !vld_ff || take;
   assign req_fire  = req.valid && req.ready;

   always_comb begin
      vld_in  = vld_ff;
      item_in = item_ff;
      if (req_fire) begin
         vld_in            = 1'b1;
         item_in.data_byte = req.data_byte;
         item_in.is_last   = req.is_last;
      end else if (take) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      item_ff <= item_in;
   end

   assign item_vld = vld_ff;
   assign item     = item_ff;

endmodule

// File: design/sepa_core.sv
// Parser core: message position, header fields, attribute walk and capture
// of the wanted attribute, and the result of a message at its last byte.
// Depends on sepa_pkg.
module sepa_core import sepa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        item_vld,
   input  item_type    item,
   input  logic        out_free,
   input  logic [15:0] wanted,
   output logic        take,
   output logic        res_load,
   output result_type  res
);

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_ATTR    = 3'd1,
      PH_SKIP    = 3'd2,
      PH_CAPTURE = 3'd3,
      PH_DONE    = 3'd4
   } phase_type;

   localparam logic [4:0] POS_TYPE_HI = 5'd0;
   localparam logic [4:0] POS_TYPE_LO = 5'd1;
   localparam logic [4:0] POS_LEN_HI  = 5'd2;
   localparam logic [4:0] POS_LEN_LO  = 5'd3;

   localparam logic [POS_W-1:0] OFF_KIND_HI = 17'd0;
   localparam logic [POS_W-1:0] OFF_KIND_LO = 17'd1;
   localparam logic [POS_W-1:0] OFF_LEN_HI  = 17'd2;
   localparam logic [POS_W-1:0] OFF_LEN_LO  = 17'd3;
   localparam logic [POS_W-1:0] OFF_FAMILY  = 17'd5;
   localparam logic [POS_W-1:0] OFF_PORT_HI = 17'd6;
   localparam logic [POS_W-1:0] OFF_PORT_LO = 17'd7;
   localparam logic [POS_W-1:0] POS_LENGTH_DONE = 17'd3;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] end_ff, end_in;
   logic [POS_W-1:0] start_ff, start_in;
   logic [15:0]      type_ff, type_in;
   logic [15:0]      kind_ff, kind_in;
   logic [15:0]      len_ff, len_in;
   phase_type        phase_ff, phase_in;
   logic [7:0]       family_ff, family_in;
   logic [15:0]      port_ff, port_in;
   logic [63:0]      addr_ff [2];
   logic [63:0]      addr_in [2];

   logic [7:0]       b;
   logic [POS_W-1:0] off;
   phase_type        cur_phase;
   logic [15:0]      len_full;
   logic [POS_W:0]   next_start;
   logic [POS_W:0]   count;
   logic [POS_W:0]   end_eff;
   logic [POS_W:0]   attr_body;
   logic [POS_W:0]   attr_end;
   logic             clear;

   assign b        = item.data_byte;
   assign off      = pos_ff - start_ff;
   assign take     = item_vld && (!item.is_last || out_free);
   assign res_load = take && item.is_last;
   assign clear    = reset || res_load;

   // State update for one byte.
   always_comb begin
      pos_in     = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 17'd1;
      end_in     = end_ff;
      start_in   = start_ff;
      type_in    = type_ff;
      kind_in    = kind_ff;
      len_in     = len_ff;
      phase_in   = phase_ff;
      family_in  = family_ff;
      port_in    = port_ff;
      addr_in[0] = addr_ff[0];
      addr_in[1] = addr_ff[1];
      cur_phase  = phase_ff;
      len_full   = {len_ff[15:8], b};
      next_start = {1'b0, start_ff} + {1'b0, ATTR_HEAD} + {2'b00, len_full};

      if (pos_ff < HEADER_BYTES) begin
         case (pos_ff[4:0])
            POS_TYPE_HI: type_in = {b, 8'h00};
            POS_TYPE_LO: type_in = {type_ff[15:8], b};
            POS_LEN_HI:  end_in  = HEADER_BYTES + {1'b0, b, 8'h00};
            POS_LEN_LO:  end_in  = end_ff + {9'd0, b};
            default: ;
         endcase
         if (pos_ff == HEADER_LAST) begin
            phase_in = PH_ATTR;
         end
      end else if (pos_ff < end_ff && phase_ff != PH_DONE) begin
         // Reaching the next attribute header ends a skip.
         if (phase_ff == PH_SKIP && pos_ff == start_ff) begin
            cur_phase = PH_ATTR;
            phase_in  = PH_ATTR;
            kind_in   = '0;
            len_in    = '0;
         end
         if (cur_phase == PH_ATTR) begin
            case (off)
               OFF_KIND_HI: kind_in = {b, 8'h00};
               OFF_KIND_LO: kind_in = {kind_ff[15:8], b};
               OFF_LEN_HI:  len_in  = {b, 8'h00};
               OFF_LEN_LO: begin
                  len_in = len_full;
                  if (kind_ff == wanted) begin
                     phase_in = PH_CAPTURE;
                  end else if (next_start + {1'b0, ATTR_HEAD} >= {1'b0, end_ff}) begin
                     phase_in = PH_DONE;
                  end else begin
                     start_in = next_start[POS_W-1:0];
                     phase_in = PH_SKIP;
                  end
               end
               default: ;
            endcase
         end else if (cur_phase == PH_CAPTURE) begin
            case (off)
               OFF_FAMILY:  family_in = b;
               OFF_PORT_HI: port_in   = {b, 8'h00};
               OFF_PORT_LO: port_in   = {port_ff[15:8], b};
               default: begin
                  // Value bytes 4 to 11 fill the first word, 12 to 19 the second,
                  // most significant byte first.
                  if (off[POS_W-1:5] == '0 && off[4:3] == 2'b01) begin
                     addr_in[0][{~off[2:0], 3'b000} +: 8] = b;
                  end else if (off[POS_W-1:5] == '0 && off[4:3] == 2'b10) begin
                     addr_in[1][{~off[2:0], 3'b000} +: 8] = b;
                  end
               end
            endcase
         end
      end
   end

   // Result of the message, from the state after this byte.
   always_comb begin
      count     = {1'b0, pos_ff} + 18'd1;
      end_eff   = count;
      if (pos_ff >= POS_LENGTH_DONE && {1'b0, end_in} < count) begin
         end_eff = {1'b0, end_in};
      end
      attr_body = {1'b0, start_in} + {1'b0, ATTR_HEAD};
      attr_end  = attr_body + {2'b00, len_in};

      res.status         = (type_in == BIND_SUCCESS_TYPE) ? ST_MISSING : ST_ABSENT;
      res.message_type   = type_in;
      res.address_family = AF_NONE;
      res.port_number    = '0;
      res.address_upper  = '0;
      res.address_lower  = '0;

      if (phase_in == PH_CAPTURE && attr_body < end_eff) begin
         if (attr_end > end_eff) begin
            res.status = ST_OVERRUN;
         end else if (family_in == FAMILY_V4) begin
            if (len_in != V4_LENGTH) begin
               res.status = ST_BAD_LENGTH;
            end else begin
               res.status         = ST_FOUND;
               res.address_family = AF_IPV4;
               res.port_number    = port_in;
               res.address_lower  = {32'h0, addr_in[0][63:32]};
            end
         end else if (family_in == FAMILY_V6) begin
            if (len_in != V6_LENGTH) begin
               res.status = ST_BAD_LENGTH;
            end else begin
               res.status         = ST_FOUND;
               res.address_family = AF_IPV6;
               res.port_number    = port_in;
               res.address_upper  = addr_in[0];
               res.address_lower  = addr_in[1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         pos_ff    <= '0;
         end_ff    <= '0;
         start_ff  <= HEADER_BYTES;
         type_ff   <= '0;
         kind_ff   <= '0;
         len_ff    <= '0;
         phase_ff  <= PH_HEADER;
         family_ff <= '0;
      end else if (take) begin
         pos_ff    <= pos_in;
         end_ff    <= end_in;
         start_ff  <= start_in;
         type_ff   <= type_in;
         kind_ff   <= kind_in;
         len_ff    <= len_in;
         phase_ff  <= phase_in;
         family_ff <= family_in;
      end
   end

   // Port and address bytes are only reported once every one of them has
   // been written in the current message, so they need no clearing.
   always_ff @(posedge clock) begin
      if (take) begin
         port_ff    <= port_in;
         addr_ff[0] <= addr_in[0];
         addr_ff[1] <= addr_in[1];
      end
   end

endmodule

// File: design/sepa_out_stage.sv
// Result register of the STUN endpoint attribute parser.
// Depends on sepa_pkg and sepa_rsp_if.
module sepa_out_stage import sepa_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type res,
   output logic       free,
   sepa_rsp_if.source rsp
);

   logic       vld_ff, vld_in;
   result_type res_ff, res_in;

   assign free = !vld_ff || rsp.ready;

   always_comb begin
      vld_in = vld_ff;
      res_in = res_ff;
      if (load) begin
         vld_in = 1'b1;
         res_in = res;
      end else if (rsp.ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      res_ff <= res_in;
   end

   assign rsp.valid          = vld_ff;
   assign rsp.status         = res_ff.status;
   assign rsp.message_type   = res_ff.message_type;
   assign rsp.address_family = res_ff.address_family;
   assign rsp.port_number    = res_ff.port_number;
   assign rsp.address_upper  = res_ff.address_upper;
   assign rsp.address_lower  = res_ff.address_lower;

endmodule

// File: design/stun_endpoint_attribute_parser.sv
// Top level of the STUN endpoint attribute parser.
// Depends on sepa_pkg, the channel interfaces, sepa_in_stage, sepa_core and
// sepa_out_stage.
//
// Usage: a STUN message enters on req one item per byte, in network order,
// with is_last set on the final byte. For every message exactly one item
// leaves on rsp: the status, the message type and, when the wanted
// attribute holds a well-formed IPv4 or IPv6 endpoint, its family, port
// and address. The attribute type to look for is written on csr, which is
// always ready; write it only between messages. After reset it is 1.
// Throughput is one byte per cycle while no last byte waits for the result
// register: each byte goes from the input register through the parser core
// into the state and, on the last byte, into the result register. The
// result register loads when the core takes the last byte from the input
// register. While rsp is stalled, bytes keep flowing; only a further last
// byte waits in the input register until the result register empties.
// Reset clears the message state and the valid flags of both stage
// registers.
module stun_endpoint_attribute_parser import sepa_pkg::*; (
   input logic        clock,
   input logic        reset,
   sepa_req_if.sink   req,
   sepa_rsp_if.source rsp,
   sepa_csr_if.sink   csr
);

   logic        csr_fire;
   logic [15:0] wanted_attr_ff;
   logic        item_vld;
   item_type    item;
   logic        take;
   logic        res_load;
   result_type  res;
   logic        out_free;

   assign csr.ready = 1'b1;
   assign csr_fire  = csr.valid && csr.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_attr_ff <= WANTED_RESET;
      end else if (csr_fire) begin
         wanted_attr_ff <= csr.wanted_attribute;
      end
   end

   sepa_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .take     (take),
      .item_vld (item_vld),
      .item     (item)
   );

   sepa_core u_core (
      .clock    (clock),
      .reset    (reset),
      .item_vld (item_vld),
      .item     (item),
      .out_free (out_free),
      .wanted   (wanted_attr_ff),
      .take     (take),
      .res_load (res_load),
      .res      (res)
   );

   sepa_out_stage u_out_stage (
      .clock (clock),
      .reset (reset),
      .load  (res_load),
      .res   (res),
      .free  (out_free),
      .rsp   (rsp)
   );

   // A result appears only after the core finished a message.
   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(res_load))
      else $error("result appeared without a finished message");

   // A held result is never overwritten by the next message.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !out_free |-> !res_load)
      else $error("result register overwritten while stalled");

   a_clean_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status != ST_FOUND) |->
         (rsp.address_family == AF_NONE && rsp.port_number == '0 &&
          rsp.address_upper == '0 && rsp.address_lower == '0))
      else $error("endpoint fields set on a failed lookup");

   a_ipv4_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.address_family == AF_IPV4) |->
         (rsp.status == ST_FOUND && rsp.address_upper == '0 &&
          rsp.address_lower[63:32] == '0))
      else $error("IPv4 result with wide address");

endmodule
